FILE: sv/rmth_pkg.sv
// package for the running median core: widths, sizes, types, sequencer states
// no dependencies

package rmth_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int CAPACITY   = 1024;
    localparam int HEAP_DEPTH = CAPACITY / 2 + 1;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int TOTAL_W    = $clog2(CAPACITY + 1);

    typedef logic [SAMPLE_W-1:0] t_key;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       start_new;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median;
        logic                       dropped;
    } t_out;

    // memory port request from the sequencer to one heap ram
    typedef struct packed {
        logic  re;
        t_addr raddr;
        logic  we;
        t_addr waddr;
        t_key  wdata;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOP_RD,
        S_DECIDE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_TOP,
        S_POP_LRD,
        S_POP_LAST,
        S_POP_RD1,
        S_POP_RD2,
        S_POP_CMP,
        S_MED_RD,
        S_OUT,
        S_DROP
    } t_state;

endpackage

FILE: sv/rmth_ram.sv
// single heap storage: one write port, one registered read port
// depends on rmth_pkg

module rmth_ram
    import rmth_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_key     o_rdata
);

    t_key r_mem [HEAP_DEPTH];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rmth_seq.sv
// heap sequencer: push and pop as sift loops over the two heap rams
// depends on rmth_pkg

module rmth_seq
    import rmth_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in      i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out     o_out_data,
    output t_mem_req o_lo_req,
    output t_mem_req o_up_req,
    input  t_key     i_lo_rdata,
    input  t_key     i_up_rdata
);

    typedef logic [ADDR_W:0] t_wide;

    // a is nearer the top than b for the heap in service
    function automatic logic f_above(input logic heap, input t_key a, input t_key b);
        f_above = heap ? (a < b) : (a > b);
    endfunction

    t_state r_state, n_state;
    t_cnt   r_lo_cnt, n_lo_cnt, r_up_cnt, n_up_cnt;
    t_key   r_key, n_key;         // key being pushed, or top moved by a pop
    t_key   r_last, n_last;       // key sinking in a pop
    t_key   r_c1, n_c1;           // first child in a pop
    t_addr  r_idx, n_idx;         // hole position
    logic   r_heap, n_heap;       // 0 lower (max), 1 upper (min)
    logic   r_rebal, n_rebal;     // push is the move after a pop
    logic   r_ovalid, n_ovalid;
    t_out   r_odata, n_odata;

    t_key     w_rd;
    t_cnt     w_cnt;
    t_addr    w_par;
    t_wide    w_c1, w_c2, w_n;
    logic     w_push_up, w_pick2, w_sink, w_pop_end;
    t_key     w_cand;
    t_addr    w_cidx;
    t_key     w_key_in;
    t_mem_req w_req;

    assign w_rd     = r_heap ? i_up_rdata : i_lo_rdata;
    assign w_cnt    = r_heap ? r_up_cnt : r_lo_cnt;
    assign w_par    = t_addr'((r_idx - t_addr'(1)) >> 1);
    assign w_c1     = {r_idx, 1'b1};
    assign w_c2     = w_c1 + t_wide'(1);
    assign w_n      = t_wide'(w_cnt);
    assign w_key_in = {~i_in_data.sample[SAMPLE_W-1], i_in_data.sample[SAMPLE_W-2:0]};

    // push: parent read back in push_cmp
    assign w_push_up = (r_idx != '0) && f_above(r_heap, r_key, w_rd);
    // pop: second child is in w_rd during pop_cmp
    assign w_pick2   = (w_c2 < w_n) && f_above(r_heap, w_rd, r_c1);
    assign w_cand    = w_pick2 ? w_rd : r_c1;
    assign w_cidx    = w_pick2 ? t_addr'(w_c2) : t_addr'(w_c1);
    assign w_sink    = f_above(r_heap, w_cand, r_last);
    assign w_pop_end = ((r_state == S_POP_RD1) && (w_c1 >= w_n)) ||
                       ((r_state == S_POP_CMP) && !w_sink);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lo_cnt <= '0;
            r_up_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lo_cnt <= n_lo_cnt;
            r_up_cnt <= n_up_cnt;
            r_ovalid <= n_ovalid;
        end
        r_key   <= n_key;
        r_last  <= n_last;
        r_c1    <= n_c1;
        r_idx   <= n_idx;
        r_heap  <= n_heap;
        r_rebal <= n_rebal;
        r_odata <= n_odata;
    end

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_lo_cnt = r_lo_cnt;
        n_up_cnt = r_up_cnt;
        n_key    = r_key;
        n_last   = r_last;
        n_c1     = r_c1;
        n_idx    = r_idx;
        n_heap   = r_heap;
        n_rebal  = r_rebal;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key = w_key_in;
                    if (i_in_data.start_new) begin
                        n_lo_cnt = '0;
                        n_up_cnt = '0;
                    end
                    if (!i_in_data.start_new &&
                        (TOTAL_W'(r_lo_cnt) + TOTAL_W'(r_up_cnt) >= TOTAL_W'(CAPACITY))) begin
                        n_state = S_DROP;
                    end else begin
                        n_state = S_TOP_RD;
                    end
                end
            end
            S_TOP_RD: n_state = S_DECIDE;
            S_DECIDE: begin
                n_heap  = !(r_lo_cnt == '0 || i_lo_rdata >= r_key);
                n_rebal = 1'b0;
                n_idx   = n_heap ? t_addr'(r_up_cnt) : t_addr'(r_lo_cnt);
                if (n_heap) n_up_cnt = r_up_cnt + t_cnt'(1);
                else        n_lo_cnt = r_lo_cnt + t_cnt'(1);
                n_state = S_PUSH_RD;
            end
            S_PUSH_RD: n_state = S_PUSH_CMP;
            S_PUSH_CMP: begin
                if (w_push_up) begin
                    n_idx   = w_par;
                    n_state = S_PUSH_RD;
                end else if (!r_rebal && r_lo_cnt > r_up_cnt + t_cnt'(1)) begin
                    n_heap  = 1'b0;
                    n_state = S_POP_TOP;
                end else if (!r_rebal && r_up_cnt > r_lo_cnt + t_cnt'(1)) begin
                    n_heap  = 1'b1;
                    n_state = S_POP_TOP;
                end else begin
                    n_state = S_MED_RD;
                end
            end
            S_POP_TOP: begin
                if (r_heap) n_up_cnt = r_up_cnt - t_cnt'(1);
                else        n_lo_cnt = r_lo_cnt - t_cnt'(1);
                n_state = S_POP_LRD;
            end
            S_POP_LRD: begin
                n_key   = w_rd;       // top moves to the other heap
                n_state = S_POP_LAST;
            end
            S_POP_LAST: begin
                n_last  = w_rd;
                n_idx   = '0;
                n_state = S_POP_RD1;
            end
            S_POP_RD1: begin
                if (!w_pop_end) n_state = S_POP_RD2;
            end
            S_POP_RD2: begin
                n_c1    = w_rd;
                n_state = S_POP_CMP;
            end
            S_POP_CMP: begin
                if (w_sink) begin
                    n_idx   = w_cidx;
                    n_state = S_POP_RD1;
                end
            end
            S_MED_RD: begin
                if (r_lo_cnt[0] == r_up_cnt[0]) n_state = S_IDLE;
                else n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid        = 1'b1;
                    n_odata.dropped = 1'b0;
                    n_odata.median  = (r_lo_cnt > r_up_cnt)
                        ? {~i_lo_rdata[SAMPLE_W-1], i_lo_rdata[SAMPLE_W-2:0]}
                        : {~i_up_rdata[SAMPLE_W-1], i_up_rdata[SAMPLE_W-2:0]};
                    n_state = S_IDLE;
                end
            end
            S_DROP: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid        = 1'b1;
                    n_odata.dropped = 1'b1;
                    n_odata.median  = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (w_pop_end) begin
            // sift done, push the moved top into the other heap
            n_heap  = !r_heap;
            n_rebal = 1'b1;
            n_idx   = r_heap ? t_addr'(r_lo_cnt) : t_addr'(r_up_cnt);
            if (r_heap) n_lo_cnt = r_lo_cnt + t_cnt'(1);
            else        n_up_cnt = r_up_cnt + t_cnt'(1);
            n_state = S_PUSH_RD;
        end
    end

    // memory requests
    always_comb begin
        w_req = '0;
        case (r_state)
            S_PUSH_RD: begin
                w_req.re    = 1'b1;
                w_req.raddr = w_par;
            end
            S_PUSH_CMP: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_idx;
                w_req.wdata = w_push_up ? w_rd : r_key;
            end
            S_POP_TOP: begin
                w_req.re    = 1'b1;
                w_req.raddr = '0;
            end
            S_POP_LRD: begin
                w_req.re    = 1'b1;
                w_req.raddr = t_addr'(w_cnt);
            end
            S_POP_RD1: begin
                if (w_pop_end) begin
                    w_req.we    = (w_n != '0);
                    w_req.waddr = r_idx;
                    w_req.wdata = r_last;
                end else begin
                    w_req.re    = 1'b1;
                    w_req.raddr = t_addr'(w_c1);
                end
            end
            S_POP_RD2: begin
                w_req.re    = 1'b1;
                w_req.raddr = t_addr'(w_c2);
            end
            S_POP_CMP: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_idx;
                w_req.wdata = w_sink ? w_cand : r_last;
            end
            default: w_req = '0;
        endcase
    end

    // both tops are read while idle and for the median
    always_comb begin
        o_lo_req = '0;
        o_up_req = '0;
        if (r_state == S_IDLE || r_state == S_MED_RD) begin
            o_lo_req.re = 1'b1;
            o_up_req.re = 1'b1;
        end else if (r_heap) begin
            o_up_req = w_req;
        end else begin
            o_lo_req = w_req;
        end
    end

endmodule

FILE: sv/running_median_two_heaps_core.sv
// top level of the running median core
// depends on rmth_pkg, rmth_seq, rmth_ram
//
// channel | dir | payload             | handshake
// in      | in  | t_in  (sample, new) | i_in_valid / o_in_ready
// out     | out | t_out (median, drop)| o_out_valid / i_out_ready
//
// a request with no sifting runs top read, decide, push read and compare,
// median read and output, then loads its result; each push level repeats
// push read and compare; a rebalance adds a pop (top and last reads, then
// per level two child reads and a compare) and a second push
// even-numbered requests give no result; dropped ones load in the drop state
// reset clears both heap counts; ram contents stay undefined
// a waiting result stalls only the final load of the next request

module running_median_two_heaps_core
    import rmth_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_mem_req w_lo_req, w_up_req;
    t_key     w_lo_rdata, w_up_rdata;

    // sequencer runs push, pop and median read
    rmth_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .o_lo_req     (w_lo_req),
        .o_up_req     (w_up_req),
        .i_lo_rdata   (w_lo_rdata),
        .i_up_rdata   (w_up_rdata)
    );

    // lower half, max ordered
    rmth_ram u_lo_ram (
        .i_clk   (i_clk),
        .i_req   (w_lo_req),
        .o_rdata (w_lo_rdata)
    );

    // upper half, min ordered
    rmth_ram u_up_ram (
        .i_clk   (i_clk),
        .i_req   (w_up_req),
        .o_rdata (w_up_rdata)
    );

endmodule

FILE: sv/rmth_chk.sv
// port checker for the running median core, bound to the top level
// depends on rmth_pkg

module rmth_chk
    import rmth_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.dropped |-> o_out_data.median == '0)
        else $error("drop carries a median");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

endmodule

bind running_median_two_heaps_core rmth_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
